>>> rtl/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

    // Operation codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_SET_DATE   = 3'd0,
        MODE_SET_DAY    = 3'd1,
        MODE_SET_MONTH  = 3'd2,
        MODE_SET_YEAR   = 3'd3,
        MODE_ADD_DAYS   = 3'd4,
        MODE_ADD_MONTHS = 3'd5,
        MODE_ADD_YEARS  = 3'd6,
        MODE_READ       = 3'd7
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MON,
        ST_QUO,
        ST_REM,
        ST_WALK,
        ST_DONE
    } cda_state_t;

    // Input word.
    typedef struct packed {
        logic [2:0]         mode;
        logic [4:0]         day_value;
        logic [3:0]         month_value;
        logic [15:0]        year_value;
        logic signed [15:0] count;
    } cda_in_t;

    // Result word.
    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
        logic [8:0]  day_of_year;
        logic [1:0]  status;
    } cda_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic div;
        logic mon;
        logic quo;
        logic rem;
        logic walk;
        logic finish;
    } cda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  neg;
        logic  walk_done;
        logic  out_free;
    } cda_sts_t;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any 16-bit x.
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    // floor(y / 25) = (y * RECIP25) >> RECIP25_SHIFT for any 16-bit y.
    localparam logic [16:0] RECIP25       = 17'd83887;
    localparam int          RECIP25_SHIFT = 21;

    // Days in a month; months outside 1..12 read as 31.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] days;
        case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> rtl/cda_ctrl.sv
`timescale 1ns / 1ps

module cda_ctrl import cda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cda_sts_t sts,
    output cda_cmd_t cmd
);

    cda_state_t state_reg;
    cda_state_t state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = (sts.mode == MODE_ADD_MONTHS) ? ST_DIV : ST_QUO;
            end
            ST_DIV: begin
                state_next = ST_MON;
            end
            ST_MON: begin
                state_next = ST_QUO;
            end
            ST_QUO: begin
                state_next = ST_REM;
            end
            ST_REM: begin
                if (sts.mode == MODE_ADD_DAYS && !sts.neg) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
            end
            ST_DIV: begin
                cmd.div = 1'b1;
            end
            ST_MON: begin
                cmd.mon = 1'b1;
            end
            ST_QUO: begin
                cmd.quo = 1'b1;
            end
            ST_REM: begin
                cmd.rem = 1'b1;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/cda_datapath.sv
`timescale 1ns / 1ps

module cda_datapath import cda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cda_in_t  s_data,
    input  cda_cmd_t cmd,
    output cda_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output cda_out_t m_data
);

    // Captured input word.
    cda_in_t     in_reg, in_next;
    // Stored date and its leap flag.
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [15:0] year_reg, year_next;
    logic        leap_reg, leap_next;
    // Working date; the year has one extra bit to show overflow.
    logic [15:0] wd_reg, wd_next;
    logic [3:0]  wm_reg, wm_next;
    logic [16:0] wy_reg, wy_next;
    // Month arithmetic and year residue mod 25.
    logic [15:0] tot_reg, tot_next;
    logic [11:0] q12_reg, q12_next;
    logic [11:0] q25_reg, q25_next;
    logic [4:0]  r25_reg, r25_next;
    // Output register.
    cda_out_t    out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    mode_t       mode;
    logic        neg;
    logic [14:0] cnt;
    logic        leap_w;
    logic [4:0]  mlen_w;
    logic [8:0]  ylen_w;
    logic        year_step;
    logic        walk_done;
    logic [4:0]  r25_inc;
    logic [31:0] prod3;
    logic [32:0] prod25;
    logic [15:0] q12x12;
    logic [15:0] rem12;
    logic [15:0] q25x25;
    logic [15:0] rem25;
    logic        date_ok;
    logic [4:0]  fd_fix;
    logic [4:0]  fd_clamp;
    logic [4:0]  fd;
    status_t     status;
    logic        accept;
    logic [4:0]  sel_d;
    logic [3:0]  sel_m;
    logic [15:0] sel_y;
    logic        sel_leap;
    logic [8:0]  doy;

    assign mode = mode_t'(in_reg.mode);
    assign neg  = in_reg.count[15];
    assign cnt  = in_reg.count[14:0];

    // Leap year from the low bits and the residue mod 25 of the working year.
    assign leap_w = (wy_reg[1:0] == 2'd0) && ((r25_reg != 5'd0) || (wy_reg[3:0] == 4'd0));
    assign mlen_w = month_len(wm_reg, leap_w);
    assign ylen_w = leap_w ? 9'd366 : 9'd365;
    assign r25_inc = (r25_reg == 5'd24) ? 5'd0 : r25_reg + 5'd1;

    // One walk step covers a whole year from January, otherwise one month.
    assign year_step = (wm_reg == 4'd1) && (wd_reg > {7'd0, ylen_w});
    assign walk_done = wy_reg[16] || (wd_reg <= {11'd0, mlen_w});

    // Division of the month total by 12 and of the year by 25.
    assign prod3  = {18'd0, tot_reg[15:2]} * {16'd0, RECIP3};
    assign q12x12 = {1'b0, q12_reg, 3'd0} + {2'd0, q12_reg, 2'd0};
    assign rem12  = tot_reg - q12x12;
    assign prod25 = {17'd0, wy_reg[15:0]} * {16'd0, RECIP25};
    assign q25x25 = {q25_reg, 4'd0} + {1'b0, q25_reg, 3'd0} + {4'd0, q25_reg};
    assign rem25  = wy_reg[15:0] - q25x25;

    // Checks and day fixes for the final step.
    assign date_ok = (wd_reg[15:5] == 11'd0) && (wd_reg[4:0] != 5'd0)
                  && (wm_reg >= 4'd1) && (wm_reg <= 4'd12)
                  && (wy_reg != 17'd0) && (wd_reg[4:0] <= mlen_w);
    assign fd_fix = (wm_reg == 4'd2 && wd_reg[4:0] == 5'd29 && !leap_w) ? 5'd28 : wd_reg[4:0];
    assign fd_clamp = (wd_reg[4:0] > mlen_w) ? mlen_w : wd_reg[4:0];

    always_comb begin
        status = STATUS_OK;
        fd     = wd_reg[4:0];
        case (mode)
            MODE_SET_DATE, MODE_SET_DAY, MODE_SET_MONTH: begin
                status = date_ok ? STATUS_OK : STATUS_INVALID;
            end
            MODE_SET_YEAR: begin
                status = (wy_reg == 17'd0) ? STATUS_INVALID : STATUS_OK;
                fd     = fd_fix;
            end
            MODE_ADD_DAYS: begin
                if (neg) begin
                    status = STATUS_INVALID;
                end else if (wy_reg[16]) begin
                    status = STATUS_OVERFLOW;
                end
            end
            MODE_ADD_MONTHS: begin
                if (neg) begin
                    status = STATUS_INVALID;
                end else if (wy_reg[16]) begin
                    status = STATUS_OVERFLOW;
                end
                fd = fd_clamp;
            end
            MODE_ADD_YEARS: begin
                if (neg) begin
                    status = STATUS_INVALID;
                end else if (wy_reg[16]) begin
                    status = STATUS_OVERFLOW;
                end
                fd = fd_fix;
            end
            default: begin
                status = STATUS_OK;
            end
        endcase
    end

    // Date that stands after the item, and its ordinal day.
    assign accept   = (status == STATUS_OK);
    assign sel_d    = accept ? fd : day_reg;
    assign sel_m    = accept ? wm_reg : month_reg;
    assign sel_y    = accept ? wy_reg[15:0] : year_reg;
    assign sel_leap = accept ? leap_w : leap_reg;
    assign doy = {4'd0, sel_d} + days_before(sel_m)
               + {8'd0, (sel_leap && sel_m > 4'd2)};

    // Next values of all registers.
    always_comb begin
        in_next        = in_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        leap_next      = leap_reg;
        wd_next        = wd_reg;
        wm_next        = wm_reg;
        wy_next        = wy_reg;
        tot_next       = tot_reg;
        q12_next       = q12_reg;
        q25_next       = q25_reg;
        r25_next       = r25_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.capture) begin
            in_next = s_data;
        end

        // Load the working date with the candidate for this operation.
        if (cmd.prep) begin
            wd_next  = {11'd0, day_reg};
            wm_next  = month_reg;
            wy_next  = {1'b0, year_reg};
            tot_next = {12'd0, month_reg} - 16'd1 + {1'b0, cnt};
            case (mode)
                MODE_SET_DATE: begin
                    wd_next = {11'd0, in_reg.day_value};
                    wm_next = in_reg.month_value;
                    wy_next = {1'b0, in_reg.year_value};
                end
                MODE_SET_DAY: begin
                    wd_next = {11'd0, in_reg.day_value};
                end
                MODE_SET_MONTH: begin
                    wm_next = in_reg.month_value;
                end
                MODE_SET_YEAR: begin
                    wy_next = {1'b0, in_reg.year_value};
                end
                MODE_ADD_DAYS: begin
                    wd_next = {11'd0, day_reg} + {1'b0, cnt};
                end
                MODE_ADD_YEARS: begin
                    wy_next = {1'b0, year_reg} + {2'd0, cnt};
                end
                default: begin
                    wd_next = {11'd0, day_reg};
                end
            endcase
        end

        // Whole years carried out of the month total.
        if (cmd.div) begin
            q12_next = prod3[RECIP3_SHIFT +: 12];
        end

        if (cmd.mon) begin
            wy_next = wy_reg + {5'd0, q12_reg};
            wm_next = rem12[3:0] + 4'd1;
        end

        // Residue of the working year mod 25 for the leap test.
        if (cmd.quo) begin
            q25_next = prod25[RECIP25_SHIFT +: 12];
        end

        if (cmd.rem) begin
            r25_next = rem25[4:0];
        end

        // Date walk: one year or one month each cycle.
        if (cmd.walk && !walk_done) begin
            if (year_step) begin
                wd_next  = wd_reg - {7'd0, ylen_w};
                wy_next  = wy_reg + 17'd1;
                r25_next = r25_inc;
            end else begin
                wd_next = wd_reg - {11'd0, mlen_w};
                if (wm_reg == 4'd12) begin
                    wm_next  = 4'd1;
                    wy_next  = wy_reg + 17'd1;
                    r25_next = r25_inc;
                end else begin
                    wm_next = wm_reg + 4'd1;
                end
            end
        end

        // Commit the date and load the result word.
        if (cmd.finish) begin
            day_next              = sel_d;
            month_next            = sel_m;
            year_next             = sel_y;
            leap_next             = sel_leap;
            out_next.cur_day      = sel_d;
            out_next.cur_month    = sel_m;
            out_next.cur_year     = sel_y;
            out_next.day_of_year  = doy;
            out_next.status       = status;
            out_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 16'd2000;
            leap_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            leap_reg      <= leap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        wd_reg  <= wd_next;
        wm_reg  <= wm_next;
        wy_reg  <= wy_next;
        tot_reg <= tot_next;
        q12_reg <= q12_next;
        q25_reg <= q25_next;
        r25_reg <= r25_next;
        out_reg <= out_next;
    end

    assign sts.mode      = mode;
    assign sts.neg       = neg;
    assign sts.walk_done = walk_done;
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/calendar_date_arithmetic_unit.sv
`timescale 1ns / 1ps

// Gregorian date register with arithmetic. The unit holds one date, 1/1/2000
// after reset, and each input word sets it (whole date, day, month or year,
// with validation), adds a non-negative count of days, months or years, or
// just reads it; every word returns exactly one result word with the stored
// date, its day of year and a status, and a rejected word leaves the date as
// it was. One word is in work at a time: after the edge that accepts a word,
// the sequencer steps through PREP, then DIV and MON when adding months,
// then QUO and REM, then, when adding days, the date walker, which moves a
// whole year per cycle from January and one month per cycle otherwise, and
// last DONE, which loads the result word once the output register is free,
// so a result word held back by m_ready stalls the unit there. A new input
// word can be accepted while the previous result is still held in the output
// register.
module calendar_date_arithmetic_unit import cda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cda_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cda_out_t m_data
);

    cda_cmd_t cmd;
    cda_sts_t sts;

    // Sequencer.
    cda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Date registers, arithmetic and output register.
    cda_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> test/tb_calendar_date_arithmetic_unit.sv
`timescale 1ns / 1ps

import cda_pkg::*;

// Tracks the stored date on its own and holds the result words still owed by the block.
class date_scoreboard;
    int unsigned held_day;
    int unsigned held_month;
    int unsigned held_year;
    cda_out_t    owed_dates[$];
    int          errors;

    function new();
        held_day   = 1;
        held_month = 1;
        held_year  = 2000;
        errors     = 0;
    endfunction

    function bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
        if (m == 2) begin
            return is_leap(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function int unsigned ordinal_of_held();
        int unsigned total;
        total = held_day;
        for (int unsigned mm = 1; mm < held_month && mm <= 12; mm++) begin
            total += month_days(mm, held_year);
        end
        return total;
    endfunction

    // Applies one input word to the held date and returns the result word it yields.
    function cda_out_t apply_word(cda_in_t w);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned dv;
        int unsigned mv;
        int unsigned yv;
        int unsigned amount;
        bit          negative;
        status_t     st;
        cda_out_t    r;
        d        = held_day;
        m        = held_month;
        y        = held_year;
        dv       = 32'(w.day_value);
        mv       = 32'(w.month_value);
        yv       = 32'(w.year_value);
        amount   = {16'd0, w.count};
        negative = w.count[15];
        st       = STATUS_OK;
        case (w.mode)
            MODE_SET_DATE: begin
                if (dv >= 1 && mv >= 1 && mv <= 12 && yv >= 1 && dv <= month_days(mv, yv)) begin
                    d = dv;
                    m = mv;
                    y = yv;
                end else begin
                    st = STATUS_INVALID;
                end
            end
            MODE_SET_DAY: begin
                if (dv >= 1 && dv <= month_days(m, y)) begin
                    d = dv;
                end else begin
                    st = STATUS_INVALID;
                end
            end
            MODE_SET_MONTH: begin
                if (mv >= 1 && mv <= 12 && d <= month_days(mv, y)) begin
                    m = mv;
                end else begin
                    st = STATUS_INVALID;
                end
            end
            MODE_SET_YEAR: begin
                if (yv >= 1) begin
                    y = yv;
                    if (m == 2 && d == 29 && !is_leap(y)) begin
                        d = 28;
                    end
                end else begin
                    st = STATUS_INVALID;
                end
            end
            MODE_ADD_DAYS: begin
                if (negative) begin
                    st = STATUS_INVALID;
                end else begin
                    d += amount;
                    while (y <= 65535 && d > month_days(m, y)) begin
                        d -= month_days(m, y);
                        m++;
                        if (m > 12) begin
                            m = 1;
                            y++;
                        end
                    end
                    if (y > 65535) begin
                        st = STATUS_OVERFLOW;
                    end
                end
            end
            MODE_ADD_MONTHS: begin
                if (negative) begin
                    st = STATUS_INVALID;
                end else begin
                    m += amount;
                    y += (m - 1) / 12;
                    m = ((m - 1) % 12) + 1;
                    if (y > 65535) begin
                        st = STATUS_OVERFLOW;
                    end else if (d > month_days(m, y)) begin
                        d = month_days(m, y);
                    end
                end
            end
            MODE_ADD_YEARS: begin
                if (negative) begin
                    st = STATUS_INVALID;
                end else begin
                    y += amount;
                    if (y > 65535) begin
                        st = STATUS_OVERFLOW;
                    end else if (m == 2 && d == 29 && !is_leap(y)) begin
                        d = 28;
                    end
                end
            end
            default: begin
            end
        endcase
        // A rejected word leaves the held date untouched.
        if (st == STATUS_OK) begin
            held_day   = d;
            held_month = m;
            held_year  = y;
        end
        r.cur_day     = held_day[4:0];
        r.cur_month   = held_month[3:0];
        r.cur_year    = held_year[15:0];
        r.day_of_year = 9'(ordinal_of_held());
        r.status      = st;
        return r;
    endfunction

    function void note_input(cda_in_t w);
        owed_dates.push_back(apply_word(w));
    endfunction

    function void check_result(cda_out_t got);
        cda_out_t want;
        if (owed_dates.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] result word with nothing owed: %p", $realtime, got);
            end
            return;
        end
        want = owed_dates.pop_front();
        if (got.cur_day !== want.cur_day || got.cur_month !== want.cur_month ||
            got.cur_year !== want.cur_year || got.day_of_year !== want.day_of_year ||
            got.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: expected d=%0d m=%0d y=%0d doy=%0d st=%0d",
                         $realtime, want.cur_day, want.cur_month, want.cur_year,
                         want.day_of_year, want.status);
                $display("[%0t]           actual   d=%0d m=%0d y=%0d doy=%0d st=%0d",
                         $realtime, got.cur_day, got.cur_month, got.cur_year,
                         got.day_of_year, got.status);
            end
        end
    endfunction

    function int pending();
        return owed_dates.size();
    endfunction

    // Any word still owed at the end of the run is a failure.
    function void close_out();
        if (owed_dates.size() != 0) begin
            errors += owed_dates.size();
            $display("%0d result words never arrived", owed_dates.size());
        end
    endfunction
endclass

module tb_calendar_date_arithmetic_unit;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cda_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cda_out_t m_data;

    date_scoreboard sb;
    bit             idle_on = 1'b1;
    int             stall_left = 0;

    calendar_date_arithmetic_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Note every input word at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_input(s_data);
        end
    end

    // Check result words and stall the result channel in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = int'($urandom_range(1, 19)) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic cda_in_t make_word(mode_t md, logic [4:0] dv, logic [3:0] mv,
                                          logic [15:0] yv, logic [15:0] cnt);
        cda_in_t w;
        w.mode        = md;
        w.day_value   = dv;
        w.month_value = mv;
        w.year_value  = yv;
        w.count       = cnt;
        return w;
    endfunction

    // Mostly plausible dates and counts, with some raw noise mixed in.
    function automatic cda_in_t random_word();
        cda_in_t     w;
        int unsigned pick;
        w.mode = mode_t'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 15) begin
            w.day_value   = 5'($urandom);
            w.month_value = 4'($urandom);
            w.year_value  = 16'($urandom);
            w.count       = 16'($urandom);
            return w;
        end
        w.day_value   = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 28))
                                                   : 5'($urandom_range(0, 31));
        w.month_value = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 12))
                                                   : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            w.year_value = 16'($urandom_range(1, 2400));
        end else if (pick < 8) begin
            w.year_value = 16'($urandom_range(65000, 65535));
        end else begin
            w.year_value = 16'($urandom_range(0, 65535));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w.count = 16'($urandom_range(16'h8000, 16'hFFFF));
        end else if (pick < 3) begin
            w.count = 16'($urandom_range(0, 32767));
        end else if (pick < 7) begin
            w.count = 16'($urandom_range(0, 3000));
        end else begin
            w.count = 16'($urandom_range(0, 60));
        end
        return w;
    endfunction

    // Present one word, after an optional random gap, and hold it until accepted.
    task automatic send_word(input cda_in_t w);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Hold the sender back until every owed result word has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: reset value, leap rules, invalid sets, overflow, clamping.
        send_word(make_word(MODE_READ, 5'd0, 4'd0, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd29, 4'd2, 16'd2000, 16'd0));
        send_word(make_word(MODE_SET_YEAR, 5'd0, 4'd0, 16'd2100, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd29, 4'd2, 16'd1900, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd0, 4'd1, 16'd2000, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd1, 4'd0, 16'd2000, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd1, 4'd15, 16'd2000, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd1, 4'd1, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd31, 4'd12, 16'd65535, 16'd0));
        send_word(make_word(MODE_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'd1));
        send_word(make_word(MODE_ADD_MONTHS, 5'd0, 4'd0, 16'd0, 16'd1));
        send_word(make_word(MODE_ADD_YEARS, 5'd0, 4'd0, 16'd0, 16'd1));
        send_word(make_word(MODE_ADD_YEARS, 5'd0, 4'd0, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd31, 4'd4, 16'd2023, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd31, 4'd1, 16'd2024, 16'd0));
        send_word(make_word(MODE_ADD_MONTHS, 5'd0, 4'd0, 16'd0, 16'd1));
        send_word(make_word(MODE_ADD_YEARS, 5'd0, 4'd0, 16'd0, 16'd1));
        send_word(make_word(MODE_SET_DAY, 5'd31, 4'd0, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_DAY, 5'd0, 4'd0, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_DATE, 5'd31, 4'd3, 16'd2024, 16'd0));
        send_word(make_word(MODE_SET_MONTH, 5'd0, 4'd4, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_MONTH, 5'd0, 4'd13, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_MONTH, 5'd0, 4'd5, 16'd0, 16'd0));
        send_word(make_word(MODE_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'h7FFF));
        send_word(make_word(MODE_ADD_DAYS, 5'd0, 4'd0, 16'd0, 16'h8000));
        send_word(make_word(MODE_ADD_MONTHS, 5'd0, 4'd0, 16'd0, 16'hFFFF));
        send_word(make_word(MODE_SET_YEAR, 5'd0, 4'd0, 16'd0, 16'd0));
        send_word(make_word(MODE_SET_YEAR, 5'd0, 4'd0, 16'd65535, 16'd0));
        send_word(make_word(MODE_ADD_MONTHS, 5'd0, 4'd0, 16'd0, 16'h7FFF));
        send_word(make_word(MODE_READ, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF));

        // Random words; one full drain midway, and no idling near the end.
        for (int i = 0; i < 520; i++) begin
            if (i == 250) begin
                drain_results();
            end
            if (i == 440) begin
                idle_on = 1'b0;
            end
            send_word(random_word());
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cda_pkg.sv
rtl/cda_ctrl.sv
rtl/cda_datapath.sv
rtl/calendar_date_arithmetic_unit.sv
test/tb_calendar_date_arithmetic_unit.sv
